// ===== rtl/core/mice_pkg.sv =====
// Shared types and constants for the monochrome icon color expander.
// No dependencies; every module of the block imports this package.
package mice_pkg;

    // Stream phase: which kind of byte the front expects next.
    typedef enum logic [1:0] {
        PH_WIDTH  = 2'd0,
        PH_HEIGHT = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    // Configuration register indexes.
    localparam logic REG_FORE = 1'b0;
    localparam logic REG_BACK = 1'b1;

    localparam int BYTE_W   = 8;
    localparam int WORD_W   = 16;
    localparam int COUNT_W  = 4;   // words per command, 1 to 8
    localparam int BIT_IDX_W = 3;  // bit position inside a byte
    localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // One classified input byte, ready for expansion.
    typedef struct packed {
        logic               is_header;
        logic [BYTE_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               icon_end;
    } cmd_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic head_valid;
    } queue_stat_t;

endpackage

// ===== rtl/core/mice_front.sv =====
// Front end: accepts icon bytes, tracks header/row/column position and
// turns each byte, zero-width row bytes aside, into an expansion command. Depends on mice_pkg.
module mice_front
    import mice_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,      // [7:0] icon_byte
    input  queue_stat_t       qstat,
    output logic              push,
    output cmd_t              push_cmd
);

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] width_reg, width_next;
    logic [BYTE_W-1:0] height_reg, height_next;
    logic [BYTE_W-1:0] row_reg, row_next;
    logic [BYTE_W-1:0] col_reg, col_next;

    logic              accept;
    logic [BYTE_W:0]   remain;
    logic [COUNT_W-1:0] n_pix;
    logic              row_end;
    logic              icon_end;

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_WIDTH;
            width_reg  <= '0;
            height_reg <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

    always_comb
    begin
        remain   = {1'b0, width_reg} - {1'b0, col_reg};
        row_end  = (remain <= 9'd8);
        n_pix    = row_end ? remain[COUNT_W-1:0] : COUNT_W'(8);
        icon_end = row_end && (({1'b0, row_reg} + 9'd1) >= {1'b0, height_reg});

        phase_next  = phase_reg;
        width_next  = width_reg;
        height_next = height_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        push        = 1'b0;
        push_cmd.is_header = 1'b1;
        push_cmd.data      = s_tdata;
        push_cmd.count     = COUNT_W'(1);
        push_cmd.icon_end  = 1'b0;

        case (phase_reg)
            PH_HEIGHT:
            begin
                if (accept)
                begin
                    height_next = s_tdata;
                    row_next    = '0;
                    col_next    = '0;
                    phase_next  = (s_tdata == '0) ? PH_WIDTH : PH_DATA;
                    push        = 1'b1;
                end
            end
            PH_DATA:
            begin
                push_cmd.is_header = 1'b0;
                push_cmd.count     = n_pix;
                push_cmd.icon_end  = icon_end;
                if (accept)
                begin
                    // A zero-width row eats its byte without producing words.
                    push = (n_pix != '0);
                    if (row_end)
                    begin
                        col_next = '0;
                        row_next = row_reg + 8'd1;
                        if (icon_end)
                        begin
                            row_next   = '0;
                            phase_next = PH_WIDTH;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + BYTE_W'(n_pix);
                    end
                end
            end
            default:
            begin
                if (accept)
                begin
                    width_next = s_tdata;
                    phase_next = PH_HEIGHT;
                    push       = 1'b1;
                end
            end
        endcase
    end

endmodule

// ===== rtl/core/mice_queue.sv =====
// Short command queue that decouples the front from the back.
// Depends on mice_pkg for the command type and depth constants.
module mice_queue
    import mice_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmd_t        push_cmd,
    input  logic        pop,
    output cmd_t        head_cmd,
    output queue_stat_t qstat
);

    cmd_t              store [QDEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_push, do_pop;

    assign qstat.full       = (cnt_reg == QCNT_W'(QDEPTH));
    assign qstat.head_valid = (cnt_reg != '0);
    assign head_cmd         = store[rd_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && qstat.head_valid;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + QPTR_W'(1) : wr_reg;
        rd_next  = do_pop ? rd_reg + QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store[wr_reg] <= push_cmd;
    end

endmodule

// ===== rtl/core/mice_back.sv =====
// Back end: expands the command at the queue head into output words, one per
// cycle unless stalled, via a registered output stage. Depends on mice_pkg.
module mice_back
    import mice_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              head_cmd,
    input  queue_stat_t       qstat,
    output logic              pop,
    input  logic [WORD_W-1:0] fore_color,
    input  logic [WORD_W-1:0] back_color,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,      // [15:0] out_word
    output logic [1:0]        m_tuser,      // [0] is_header, [1] last_of_item
    output logic              m_tlast       // icon_done
);

    logic [BIT_IDX_W-1:0] idx_reg, idx_next;
    logic                 valid_reg, valid_next;
    logic [WORD_W-1:0]    word_reg, word_next;
    logic                 hdr_reg, hdr_next;
    logic                 last_reg, last_next;
    logic                 done_reg, done_next;

    logic                 load;
    logic                 final_word;
    logic [BYTE_W-1:0]    bit_mask;

    assign load       = qstat.head_valid && (!valid_reg || m_tready);
    assign final_word = ({1'b0, idx_reg} + COUNT_W'(1)) == head_cmd.count;
    assign bit_mask   = MSB_MASK >> idx_reg;
    assign pop        = load && final_word;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg && !m_tready;
        word_next  = word_reg;
        hdr_next   = hdr_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (load)
        begin
            valid_next = 1'b1;
            hdr_next   = head_cmd.is_header;
            last_next  = final_word;
            done_next  = final_word && head_cmd.icon_end;
            if (head_cmd.is_header)
                word_next = {{(WORD_W-BYTE_W){1'b0}}, head_cmd.data};
            else if ((head_cmd.data & bit_mask) != '0)
                word_next = fore_color;
            else
                word_next = back_color;
            idx_next = final_word ? '0 : idx_reg + BIT_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        hdr_reg  <= hdr_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = word_reg;
    assign m_tuser  = {last_reg, hdr_reg};
    assign m_tlast  = done_reg;

endmodule

// ===== rtl/core/mono_icon_color_expander.sv =====
// Top level of the monochrome icon color expander: configuration registers,
// front end, command queue and back end. Depends on mice_pkg and all mice_* modules.
//
// An icon arrives as bytes: width, height, then row bitmap bytes, MSB first,
// each row padded to a byte. Width and height come back as header words; each
// bitmap bit inside the row becomes a fore or back color word, padding bits
// produce nothing. The output port moves one word per cycle while m_tready is high,
// so a full data byte gives 8 words, a header byte one, a row's last byte 1 to 8;
// the input takes a byte every cycle while the four-entry command queue has room,
// and a zero-width row byte is taken without any output. The user must write colors
// through cfg_we/cfg_addr/cfg_wdata while the block is idle; it is not enforced.
module mono_icon_color_expander
    import mice_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_addr,
    input  logic [WORD_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,      // [7:0] icon_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata,      // [15:0] out_word
    output logic [1:0]        m_tuser,      // [0] is_header, [1] last_of_item
    output logic              m_tlast       // icon_done
);

    logic [WORD_W-1:0] fore_reg, fore_next;
    logic [WORD_W-1:0] back_reg, back_next;

    logic        push, pop;
    cmd_t        push_cmd, head_cmd;
    queue_stat_t qstat;

    always_comb
    begin
        fore_next = fore_reg;
        back_next = back_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_FORE: fore_next = cfg_wdata;
                REG_BACK: back_next = cfg_wdata;
                default:  fore_next = fore_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fore_reg <= 16'hFFFF;
            back_reg <= 16'h0000;
        end
        else
        begin
            fore_reg <= fore_next;
            back_reg <= back_next;
        end
    end

    mice_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .qstat    (qstat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mice_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    mice_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .qstat      (qstat),
        .pop        (pop),
        .fore_color (fore_reg),
        .back_color (back_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // The end of an icon is always the last word of its byte and never a header.
    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1] && !m_tuser[0])
        else $error("icon_done on a header or mid-byte word");

    // A header is a single word that carries an 8-bit size.
    a_header_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1] && (m_tdata[15:8] == 8'h00))
        else $error("malformed header word");

    // A push must never be dropped by a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("command pushed into full queue");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for mono_icon_color_expander: it drives icon byte streams,
// predicts the header and pixel words of every byte and compares each word at the output.
// Depends on mice_pkg and the RTL of the block.
module tb_top;
    import mice_pkg::*;

    localparam int DRAIN_CYCLES = 32;
    localparam int DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              is_header;
        logic              last_of_item;
        logic              icon_done;
    } pixel_word_t;

    // Predicts the words of each accepted icon byte and checks the output words in order.
    class icon_pixel_scoreboard;
        phase_t            phase;
        logic [BYTE_W-1:0] width;
        logic [BYTE_W-1:0] height;
        logic [BYTE_W-1:0] rows_done;
        logic [BYTE_W-1:0] cols_done;
        logic [WORD_W-1:0] fore;
        logic [WORD_W-1:0] back;
        pixel_word_t       pixel_words[$];
        int                errors;

        function new();
            phase     = PH_WIDTH;
            width     = '0;
            height    = '0;
            rows_done = '0;
            cols_done = '0;
            fore      = 16'hFFFF;
            back      = 16'h0000;
            errors    = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        function void set_colors(logic [WORD_W-1:0] fore_value, logic [WORD_W-1:0] back_value);
            fore = fore_value;
            back = back_value;
        endfunction

        function void expand_byte(logic [BYTE_W-1:0] value);
            int          remain;
            int          n;
            bit          row_end;
            bit          icon_end;
            pixel_word_t w;
            if (phase == PH_HEIGHT)
            begin
                height    = value;
                rows_done = '0;
                cols_done = '0;
                phase     = (value == 0) ? PH_WIDTH : PH_DATA;
                pixel_words.push_back({WORD_W'(value), 1'b1, 1'b1, 1'b0});
            end
            else if (phase != PH_DATA)
            begin
                width = value;
                phase = PH_HEIGHT;
                pixel_words.push_back({WORD_W'(value), 1'b1, 1'b1, 1'b0});
            end
            else
            begin
                remain   = int'(width) - int'(cols_done);
                n        = (remain > 8) ? 8 : remain;
                row_end  = (remain <= 8);
                icon_end = row_end && (int'(rows_done) + 1 >= int'(height));
                for (int i = 0; i < n; i++)
                begin
                    w.word         = ((value & (MSB_MASK >> i)) != 0) ? fore : back;
                    w.is_header    = 1'b0;
                    w.last_of_item = (i + 1 == n);
                    w.icon_done    = (i + 1 == n) && icon_end;
                    pixel_words.push_back(w);
                end
                if (row_end)
                begin
                    cols_done = '0;
                    rows_done = rows_done + 1'b1;
                    if (icon_end)
                    begin
                        rows_done = '0;
                        phase     = PH_WIDTH;
                    end
                end
                else
                begin
                    cols_done = cols_done + BYTE_W'(n);
                end
            end
        endfunction

        function void compare_word(pixel_word_t got);
            pixel_word_t want;
            if (pixel_words.size() == 0)
            begin
                flag($sformatf("unexpected word %h hdr=%b last=%b done=%b",
                               got.word, got.is_header, got.last_of_item, got.icon_done));
                return;
            end
            want = pixel_words.pop_front();
            if (got !== want)
                flag($sformatf("word %h/%h hdr %b/%b last %b/%b done %b/%b (expected/actual)",
                               want.word, got.word, want.is_header, got.is_header,
                               want.last_of_item, got.last_of_item,
                               want.icon_done, got.icon_done));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_addr;
    logic [WORD_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;    // [7:0] icon_byte
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [WORD_W-1:0] m_tdata;    // [15:0] out_word
    logic [1:0]        m_tuser;    // [0] is_header, [1] last_of_item
    logic              m_tlast;    // icon_done

    icon_pixel_scoreboard sb = new();
    bit calm = 1'b0;
    int bytes_sent = 0;

    mono_icon_color_expander dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 7);
    end

    // Inputs only change at the rising edge, so the values seen at the falling edge are
    // exactly the ones the next rising edge takes. Inputs are noted before outputs.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.expand_byte(s_tdata);
            if (m_tvalid && m_tready)
                sb.compare_word({m_tdata, m_tuser[0], m_tuser[1], m_tlast});
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] value);
        while (!calm && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        bytes_sent++;
    endtask

    task automatic push_icon(input int w, input int h);
        int per_row;
        per_row = (w == 0) ? 1 : (w + 7) / 8;
        push_byte(BYTE_W'(w));
        push_byte(BYTE_W'(h));
        repeat (h * per_row) push_byte(BYTE_W'($urandom_range(255)));
    endtask

    task automatic push_random_icons(input int budget);
        int start;
        int pick;
        int w;
        int h;
        start = bytes_sent;
        while (bytes_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                w = 0;
            else if (pick < 14)
                w = $urandom_range(255);
            else
                w = $urandom_range(24, 1);
            if ($urandom_range(9) == 0)
                h = 0;
            else if (pick >= 8 && pick < 14)
                h = 1;
            else
                h = $urandom_range(4, 1);
            push_icon(w, h);
        end
    endtask

    // Zero-width rows produce no words, so the queue alone does not prove the block is idle.
    task automatic drain();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.pixel_words.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        while (sb.pixel_words.size() != 0)
        begin
            sb.flag("expected word never arrived");
            void'(sb.pixel_words.pop_front());
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_colors(input logic [WORD_W-1:0] fore_value,
                                input logic [WORD_W-1:0] back_value);
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_FORE;
        cfg_wdata <= fore_value;
        @(posedge clk);
        cfg_addr  <= REG_BACK;
        cfg_wdata <= back_value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_colors(fore_value, back_value);
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_addr  <= REG_FORE;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part with the reset colors: zero height, zero width, padded
        // last bytes and a row that spans two bytes.
        push_byte(8'd0);   push_byte(8'd0);
        push_byte(8'd255); push_byte(8'd0);
        push_byte(8'd5);   push_byte(8'd0);
        push_byte(8'd0);   push_byte(8'd2);   push_byte(8'hFF); push_byte(8'h00);
        push_byte(8'd3);   push_byte(8'd2);   push_byte(8'hA0); push_byte(8'h5F);
        push_byte(8'd9);   push_byte(8'd1);   push_byte(8'hFF); push_byte(8'h80);
        push_byte(8'd8);   push_byte(8'd1);   push_byte(8'h00);
        drain();

        write_colors(16'h0000, 16'hFFFF);
        push_random_icons(16);
        drain();

        // A stretch with neither side stalling.
        write_colors(WORD_W'($urandom), WORD_W'($urandom));
        calm = 1'b1;
        push_random_icons(16);
        push_icon(255, 1);
        calm = 1'b0;
        drain();

        write_colors(WORD_W'($urandom), WORD_W'($urandom));
        push_random_icons(16);
        drain();

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== mono_icon_color_expander.f =====
rtl/core/mice_pkg.sv
rtl/core/mice_front.sv
rtl/core/mice_queue.sv
rtl/core/mice_back.sv
rtl/core/mono_icon_color_expander.sv
bench/tb_top.sv
